// File: design/b64sc_pkg.sv
// Shared types, constants and character mapping functions for the base64 stream codec.
package b64sc_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] PAD_CHAR  = 8'h3d;
  localparam logic [6:0] BAD_VALUE = 7'd64;

  localparam logic [0:63][7:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One completed group: up to four result bytes, already packed in output order.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic            has_data;
    logic            last;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    return ALPHABET[idx];
  endfunction

  // Maps a character to its 6-bit value; padding and foreign characters give 64.
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [6:0] v;
    v = BAD_VALUE;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = 7'(c - 8'd65);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = 7'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c + 8'd4);
    end else if (c == 8'h2b) begin
      v = 7'd62;
    end else if (c == 8'h2f) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// File: design/b64sc_front.sv
// Front end: accepts input bytes, tracks the group state and builds one job per finished group or stream end.
module b64sc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  input  logic          in_valid,
  input  logic [7:0]    data_in,
  input  logic          stream_last,
  input  logic          queue_full,
  output logic          in_stall,
  output logic          push,
  output b64sc_pkg::job_t job
);
  import b64sc_pkg::*;

  logic        direction;
  logic [1:0]  pos;
  logic [20:0] held;
  logic [1:0]  pos_next;
  logic [20:0] held_next;
  logic        accept;
  logic        job_ready;

  logic [7:0]  b0;
  logic [7:0]  b1;
  logic [6:0]  v;
  logic [6:0]  c0;
  logic [6:0]  c1;
  logic [6:0]  c2;
  logic [7:0]  d0;
  logic [7:0]  d1;
  logic [7:0]  d2;
  logic        c2_ok;
  logic        v_ok;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && job_ready;

  assign b0 = held[15:8];
  assign b1 = held[7:0];
  assign v  = dec_value(data_in);
  assign c0 = held[20:14];
  assign c1 = held[13:7];
  assign c2 = held[6:0];

  // Decoded bytes keep only their low eight bits.
  assign d0 = {c0[5:0], 2'b00} + {5'b0, c1[6:4]};
  assign d1 = {c1[3:0], 4'b0000} + {3'b0, c2[6:2]};
  assign d2 = {c2[1:0], 6'b000000} + {1'b0, v};
  assign c2_ok = (c2 != BAD_VALUE);
  assign v_ok  = (v != BAD_VALUE);

  always_comb begin
    job           = '0;
    job.has_data  = 1'b1;
    job.last      = stream_last;
    job_ready     = 1'b0;
    pos_next      = pos;
    held_next     = held;
    if (!direction) begin
      if (pos == 2'd2) begin
        job.bytes[0] = enc_char(b0[7:2]);
        job.bytes[1] = enc_char({b0[1:0], b1[7:4]});
        job.bytes[2] = enc_char({b1[3:0], data_in[7:6]});
        job.bytes[3] = enc_char(data_in[5:0]);
        job.cnt_m1   = 2'd3;
        job_ready    = 1'b1;
        pos_next     = 2'd0;
        held_next    = '0;
      end else if (!stream_last) begin
        pos_next  = pos + 2'd1;
        held_next = {5'b0, b1, data_in};
      end else begin
        if (pos == 2'd0) begin
          job.bytes[0] = enc_char(data_in[7:2]);
          job.bytes[1] = enc_char({data_in[1:0], 4'b0000});
          job.bytes[2] = PAD_CHAR;
        end else begin
          job.bytes[0] = enc_char(b1[7:2]);
          job.bytes[1] = enc_char({b1[1:0], data_in[7:4]});
          job.bytes[2] = enc_char({data_in[3:0], 2'b00});
        end
        job.bytes[3] = PAD_CHAR;
        job.cnt_m1   = 2'd3;
        job_ready    = 1'b1;
        pos_next     = 2'd0;
        held_next    = '0;
      end
    end else begin
      if (pos != 2'd3) begin
        pos_next  = pos + 2'd1;
        held_next = {held[13:0], v};
        if (stream_last) begin
          // An unfinished group is dropped and only an end marker goes out.
          job.has_data = 1'b0;
          job_ready    = 1'b1;
          pos_next     = 2'd0;
          held_next    = '0;
        end
      end else begin
        job.bytes[0] = d0;
        job.bytes[1] = c2_ok ? d1 : d2;
        job.bytes[2] = d2;
        job.cnt_m1   = {1'b0, c2_ok} + {1'b0, v_ok};
        job_ready    = 1'b1;
        pos_next     = 2'd0;
        held_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      pos       <= '0;
      held      <= '0;
    end else if (cfg_write) begin
      direction <= cfg_data;
      pos       <= '0;
      held      <= '0;
    end else if (accept) begin
      pos  <= pos_next;
      held <= held_next;
    end
  end

endmodule

// File: design/b64sc_queue.sv
// Short job queue that decouples the front end from the output serializer.
module b64sc_queue #(
  parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64sc_pkg::job_t wr_job,
  input  logic            pop,
  output b64sc_pkg::job_t rd_job,
  output logic            full,
  output logic            empty
);
  import b64sc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// File: design/b64sc_back.sv
// Back end: serializes each queued job into results through the output register.
module b64sc_back (
  input  logic            clk,
  input  logic            rst,
  input  b64sc_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      data_out,
  output logic            has_data,
  output logic            run_last,
  output logic            stream_end
);
  import b64sc_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_one;

  assign load      = !empty && (!out_valid || !out_stall);
  assign final_one = (idx == head.cnt_m1);
  assign pop       = load && final_one;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= final_one ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_out   <= head.bytes[idx];
      has_data   <= head.has_data;
      run_last   <= final_one;
      stream_end <= final_one && head.last;
    end
  end

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> run_last)
    else $error("stream end flagged on a result that does not close its request");
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> run_last && stream_end && data_out == 8'd0)
    else $error("malformed bare end marker");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx <= head.cnt_m1)
    else $error("serializer index beyond job length");

endmodule

// File: design/base64_stream_codec.sv
// Top level of the base64 stream codec: front end, job queue and output serializer.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------------------
//  input   | in        | in_valid / in_stall      | data_in[7:0], stream_last
//  output  | out       | out_valid / out_stall    | data_out[7:0], has_data, run_last,
//          |           |                          | stream_end
//  config  | in        | cfg_write                | cfg_data (direction: 0 encode, 1 decode)
//
// The front end takes one request per cycle whenever the job queue has room. A request
// that completes a group, or ends the stream, turns into one job of one to four results.
// The output register sends one result per cycle while out_stall is low. In sustained
// encoding the serializer is the limit, since three bytes give four results. In decoding
// the front end is the limit, since four characters give at most three results. The
// results of a request pass through the job queue and then through the output register.
// Reset is synchronous and puts the block in encode mode with empty group state and an
// empty queue. A stalled output only holds its register; the queue soaks up the front end
// until it fills, and then in_stall rises.
module base64_stream_codec #(
  parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_in,
  input  logic       stream_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_out,
  output logic       has_data,
  output logic       run_last,
  output logic       stream_end
);
  import b64sc_pkg::*;

  job_t new_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  // Classifies each request and builds the result bytes of a finished group.
  b64sc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .data_in     (data_in),
    .stream_last (stream_last),
    .queue_full  (queue_full),
    .in_stall    (in_stall),
    .push        (push),
    .job         (new_job)
  );

  // Holds finished jobs so that an output stall does not reach the input at once.
  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (new_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (queue_full),
    .empty  (queue_empty)
  );

  // Sends the results of the oldest job one per cycle while out_stall is low and marks its last one.
  b64sc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .empty      (queue_empty),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .data_out   (data_out),
    .has_data   (has_data),
    .run_last   (run_last),
    .stream_end (stream_end)
  );

endmodule
